// File: hw/rtl/relay_matrix_image_controller_defines.svh
// ----------------------------------------------------------------------------
// relay matrix image controller: assertion macros
// shared concurrent check wrappers, clocked on clk and quiet in reset
// ----------------------------------------------------------------------------
`ifndef RELAY_MATRIX_IMAGE_CONTROLLER_DEFINES_SVH
`define RELAY_MATRIX_IMAGE_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define RMIC_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmic check failed");

// next-cycle implication
`define RMIC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmic check failed");

`endif

// File: hw/rtl/rmic_pkg.sv
// ----------------------------------------------------------------------------
// rmic_pkg
// types, codes and helpers shared by the relay matrix image controller
// ----------------------------------------------------------------------------
package rmic_pkg;

    localparam int BOARDS_DEF   = 5;
    localparam int CHANNELS_DEF = 46;
    localparam int BUSES_DEF    = 8;

    localparam int MASK_W     = 5;
    localparam int DIRTY_W    = 5;
    localparam int OP_W       = 2;
    localparam int BUS_W      = 3;
    localparam int COL_W      = 8;
    localparam int SEL_W      = 3;
    localparam int BYTE_W     = 8;
    localparam int OUTB_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // fixed-point reciprocal used to split a column into board and channel
    localparam int RECIP_SHIFT = 24;

    typedef enum logic [OP_W-1:0] {
        OP_CONNECT    = 2'd0,
        OP_DISCONNECT = 2'd1,
        OP_CLEAR_ALL  = 2'd2,
        OP_SHIFT_OUT  = 2'd3
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOARD_PRESENT_MASK = 1'b0,
        CFG_BUS_SWITCH_ENABLE  = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DIV,
        ST_DECODE,
        ST_CH_RD,
        ST_CH_WR,
        ST_BS_RD,
        ST_BS_WR,
        ST_SH_RD,
        ST_SH_EMIT,
        ST_SWEEP
    } state_t;

    typedef enum logic [1:0] {
        ADDR_CH,
        ADDR_BS,
        ADDR_SHIFT,
        ADDR_SWEEP
    } addr_sel_t;

    typedef struct packed {
        logic      load;
        logic      divide;
        logic      decode;
        logic      mem_rd;
        logic      mem_wr;
        addr_sel_t addr_sel;
        logic      sweep_step;
        logic      sweep_force;
        logic      shift_init;
        logic      shift_step;
        logic      set_dirty;
        logic      clr_dirty;
        logic      set_dirty_all;
        logic      emit;
        logic      emit_byte;
    } rmic_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    item_ok;
        logic    bse;
        logic    cnt_zero;
        logic    sweep_last;
    } rmic_stat_t;

    // presence bit of a board; slots beyond the mask are never fitted
    function automatic logic present_bit(logic [MASK_W-1:0] mask, logic [7:0] bd);
        logic [7:0] wide;
        wide = {3'b000, mask};
        return (bd < 8'(MASK_W)) ? wide[bd[2:0]] : 1'b0;
    endfunction

    // one bit for every board slot below the board count
    function automatic logic [DIRTY_W-1:0] board_limit(int n);
        logic [DIRTY_W-1:0] lim;
        lim = '0;
        for (int b = 0; b < DIRTY_W; b++)
        begin
            lim[b] = (b < n);
        end
        return lim;
    endfunction

endpackage

// File: hw/rtl/rmic_ctrl.sv
// ----------------------------------------------------------------------------
// rmic_ctrl
// sequencer: reset clearing pass, column split, read-modify-write, clear-all sweep, shift-out
// ----------------------------------------------------------------------------
`include "relay_matrix_image_controller_defines.svh"

module rmic_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  rmic_pkg::rmic_stat_t stat,
    output rmic_pkg::rmic_cmd_t  cmd,
    output logic                busy
);

    rmic_pkg::state_t state_reg;
    rmic_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rmic_pkg::ST_INIT;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rmic_pkg::ST_INIT:
            begin
                if (stat.sweep_last)
                    state_next = rmic_pkg::ST_IDLE;
            end
            rmic_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = rmic_pkg::ST_DIV;
            end
            rmic_pkg::ST_DIV:
                state_next = rmic_pkg::ST_DECODE;
            rmic_pkg::ST_DECODE:
            begin
                priority if (stat.op == rmic_pkg::OP_CLEAR_ALL)
                    state_next = rmic_pkg::ST_SWEEP;
                else if (!stat.item_ok)
                    state_next = rmic_pkg::ST_IDLE;
                else if (stat.op == rmic_pkg::OP_SHIFT_OUT)
                    state_next = rmic_pkg::ST_SH_RD;
                else
                    state_next = rmic_pkg::ST_CH_RD;
            end
            rmic_pkg::ST_CH_RD:
                state_next = rmic_pkg::ST_CH_WR;
            rmic_pkg::ST_CH_WR:
            begin
                if (stat.op == rmic_pkg::OP_CONNECT && stat.bse)
                    state_next = rmic_pkg::ST_BS_RD;
                else
                    state_next = rmic_pkg::ST_IDLE;
            end
            rmic_pkg::ST_BS_RD:
                state_next = rmic_pkg::ST_BS_WR;
            rmic_pkg::ST_BS_WR:
                state_next = rmic_pkg::ST_IDLE;
            rmic_pkg::ST_SH_RD:
                state_next = rmic_pkg::ST_SH_EMIT;
            rmic_pkg::ST_SH_EMIT:
            begin
                if (stat.cnt_zero)
                    state_next = rmic_pkg::ST_IDLE;
                else
                    state_next = rmic_pkg::ST_SH_RD;
            end
            rmic_pkg::ST_SWEEP:
            begin
                if (stat.sweep_last)
                    state_next = rmic_pkg::ST_IDLE;
            end
            default:
                state_next = rmic_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.addr_sel = rmic_pkg::ADDR_CH;
        busy         = (state_reg != rmic_pkg::ST_IDLE);
        unique case (state_reg)
            rmic_pkg::ST_INIT:
            begin
                cmd.mem_wr      = 1'b1;
                cmd.addr_sel    = rmic_pkg::ADDR_SWEEP;
                cmd.sweep_step  = 1'b1;
                cmd.sweep_force = 1'b1;
            end
            rmic_pkg::ST_IDLE:
                cmd.load = start;
            rmic_pkg::ST_DIV:
                cmd.divide = 1'b1;
            rmic_pkg::ST_DECODE:
            begin
                cmd.decode = 1'b1;
                if (stat.op != rmic_pkg::OP_CLEAR_ALL)
                begin
                    if (!stat.item_ok)
                        cmd.emit = 1'b1;
                    else if (stat.op == rmic_pkg::OP_SHIFT_OUT)
                    begin
                        cmd.shift_init = 1'b1;
                        cmd.clr_dirty  = 1'b1;
                    end
                end
            end
            rmic_pkg::ST_CH_RD:
            begin
                cmd.mem_rd   = 1'b1;
                cmd.addr_sel = rmic_pkg::ADDR_CH;
            end
            rmic_pkg::ST_CH_WR:
            begin
                cmd.mem_wr    = 1'b1;
                cmd.addr_sel  = rmic_pkg::ADDR_CH;
                cmd.set_dirty = 1'b1;
                cmd.emit      = !(stat.op == rmic_pkg::OP_CONNECT && stat.bse);
            end
            rmic_pkg::ST_BS_RD:
            begin
                cmd.mem_rd   = 1'b1;
                cmd.addr_sel = rmic_pkg::ADDR_BS;
            end
            rmic_pkg::ST_BS_WR:
            begin
                cmd.mem_wr   = 1'b1;
                cmd.addr_sel = rmic_pkg::ADDR_BS;
                cmd.emit     = 1'b1;
            end
            rmic_pkg::ST_SH_RD:
            begin
                cmd.mem_rd   = 1'b1;
                cmd.addr_sel = rmic_pkg::ADDR_SHIFT;
            end
            rmic_pkg::ST_SH_EMIT:
            begin
                cmd.emit       = 1'b1;
                cmd.emit_byte  = 1'b1;
                cmd.shift_step = 1'b1;
            end
            rmic_pkg::ST_SWEEP:
            begin
                cmd.mem_wr        = 1'b1;
                cmd.addr_sel      = rmic_pkg::ADDR_SWEEP;
                cmd.sweep_step    = 1'b1;
                cmd.set_dirty_all = stat.sweep_last;
                cmd.emit          = stat.sweep_last;
            end
            default:
                cmd = '0;
        endcase
    end

    `RMIC_ASSERT_NEXT(a_accept_leaves_idle, state_reg == rmic_pkg::ST_IDLE && start, state_reg == rmic_pkg::ST_DIV)
    `RMIC_ASSERT_NOW(a_bus_switch_only_connect, state_reg == rmic_pkg::ST_BS_RD, stat.op == rmic_pkg::OP_CONNECT && stat.bse)
    `RMIC_ASSERT_NEXT(a_sweep_returns_idle, state_reg == rmic_pkg::ST_SWEEP && stat.sweep_last, state_reg == rmic_pkg::ST_IDLE)

endmodule

// File: hw/rtl/rmic_datapath.sv
// ----------------------------------------------------------------------------
// rmic_datapath
// config registers, column split, relay image memory, dirty mask, result beat
// ----------------------------------------------------------------------------
`include "relay_matrix_image_controller_defines.svh"

module rmic_datapath #(
    parameter int BOARDS             = rmic_pkg::BOARDS_DEF,
    parameter int CHANNELS_PER_BOARD = rmic_pkg::CHANNELS_DEF,
    parameter int BUSES              = rmic_pkg::BUSES_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  rmic_pkg::rmic_cmd_t               cmd,
    output rmic_pkg::rmic_stat_t              stat,
    input  logic [rmic_pkg::OP_W-1:0]         opcode,
    input  logic [rmic_pkg::BUS_W-1:0]        bus_line,
    input  logic [rmic_pkg::COL_W-1:0]        column,
    input  logic [rmic_pkg::SEL_W-1:0]        board_sel,
    input  logic                              cfg_write,
    input  logic [rmic_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rmic_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              strobe,
    output logic                              status,
    output logic [rmic_pkg::BYTE_W-1:0]       image_byte,
    output logic [rmic_pkg::OUTB_W-1:0]       out_board,
    output logic [rmic_pkg::DIRTY_W-1:0]      dirty_boards,
    output logic                              last
);

    localparam int BPB    = CHANNELS_PER_BOARD + 1;
    localparam int TOTAL  = BOARDS * BPB;
    localparam int ADDR_W = $clog2(TOTAL);
    localparam int OFF_W  = $clog2(BPB);
    localparam int CH_W   = (CHANNELS_PER_BOARD > 1) ? $clog2(CHANNELS_PER_BOARD) : 1;
    localparam int BD_W   = (BOARDS > 1) ? $clog2(BOARDS) : 1;
    localparam logic [24:0] RECIP =
        25'(((1 << rmic_pkg::RECIP_SHIFT) + CHANNELS_PER_BOARD - 1) / CHANNELS_PER_BOARD);
    localparam logic [rmic_pkg::DIRTY_W-1:0] BOARD_LIM = rmic_pkg::board_limit(BOARDS);

    // configuration
    logic [rmic_pkg::MASK_W-1:0] mask_reg;
    logic                        bse_reg;

    // item registers
    rmic_pkg::opcode_t             op_reg;
    logic [rmic_pkg::BUS_W-1:0]    bus_reg;
    logic [rmic_pkg::COL_W-1:0]    col_reg;
    logic [rmic_pkg::SEL_W-1:0]    sel_reg;
    logic [7:0]                    bd_reg;
    logic [CH_W-1:0]               ch_reg;
    logic [ADDR_W-1:0]             base_reg;
    logic [OFF_W-1:0]              cnt_reg;
    logic [rmic_pkg::BYTE_W-1:0]   rdata_reg;
    logic [rmic_pkg::DIRTY_W-1:0]  dirty_reg;
    logic [rmic_pkg::DIRTY_W-1:0]  dirty_next;

    // clearing sweep
    logic [ADDR_W-1:0] sweep_addr_reg;
    logic [OFF_W-1:0]  sweep_off_reg;
    logic [BD_W-1:0]   sweep_bd_reg;
    logic              sweep_last;

    // result beat
    logic                          strobe_reg;
    logic                          status_reg;
    logic [rmic_pkg::BYTE_W-1:0]   image_byte_reg;
    logic [rmic_pkg::OUTB_W-1:0]   out_board_reg;
    logic [rmic_pkg::DIRTY_W-1:0]  dirty_boards_reg;
    logic                          last_reg;

    logic [rmic_pkg::BYTE_W-1:0]   relay_image_reg [TOTAL];

    logic [32:0]                   quot_full;
    logic [13:0]                   ch_full;
    logic [14:0]                   base_full;
    logic [7:0]                    board;
    logic                          board_ok;
    logic                          bus_ok;
    logic                          item_ok;
    logic [rmic_pkg::OUTB_W-1:0]   board_tag;
    logic [rmic_pkg::DIRTY_W-1:0]  board_bit;
    logic [rmic_pkg::BYTE_W-1:0]   bus_bit;
    logic [ADDR_W-1:0]             mem_addr;
    logic [rmic_pkg::BYTE_W-1:0]   wdata;
    logic                          mem_we;

    assign quot_full = 33'(col_reg) * 33'(RECIP);
    assign ch_full   = 14'(col_reg) - 14'(bd_reg) * 14'(CHANNELS_PER_BOARD);
    assign board     = (op_reg == rmic_pkg::OP_SHIFT_OUT) ? 8'(sel_reg) : bd_reg;
    assign base_full = 15'(board) * 15'(BPB);
    assign board_ok  = (board < 8'(BOARDS)) && rmic_pkg::present_bit(mask_reg, board);
    assign bus_ok    = ({1'b0, bus_reg} < 4'(BUSES));
    assign item_ok   = board_ok && (op_reg == rmic_pkg::OP_SHIFT_OUT || bus_ok);
    assign board_tag = (op_reg != rmic_pkg::OP_CLEAR_ALL && board < 8'(BOARDS))
                       ? board[2:0] : '0;
    assign board_bit = (board < 8'(rmic_pkg::DIRTY_W))
                       ? rmic_pkg::DIRTY_W'(1) << board[2:0] : '0;
    assign bus_bit   = rmic_pkg::BYTE_W'(1) << bus_reg;
    assign sweep_last = (sweep_addr_reg == ADDR_W'(TOTAL - 1));

    assign stat.op         = op_reg;
    assign stat.item_ok    = item_ok;
    assign stat.bse        = bse_reg;
    assign stat.cnt_zero   = (cnt_reg == '0);
    assign stat.sweep_last = sweep_last;

    always_comb
    begin
        dirty_next = dirty_reg;
        if (cmd.set_dirty)
            dirty_next = dirty_next | board_bit;
        if (cmd.set_dirty_all)
            dirty_next = dirty_next | (mask_reg & BOARD_LIM);
        if (cmd.clr_dirty)
            dirty_next = dirty_next & ~board_bit;
    end

    always_comb
    begin
        mem_we = cmd.mem_wr;
        unique case (cmd.addr_sel)
            rmic_pkg::ADDR_CH:
            begin
                mem_addr = base_reg + ADDR_W'(ch_reg);
                wdata    = (op_reg == rmic_pkg::OP_CONNECT) ? (rdata_reg | bus_bit)
                                                            : (rdata_reg & ~bus_bit);
            end
            rmic_pkg::ADDR_BS:
            begin
                mem_addr = base_reg + ADDR_W'(CHANNELS_PER_BOARD);
                wdata    = rdata_reg | bus_bit;
            end
            rmic_pkg::ADDR_SHIFT:
            begin
                mem_addr = base_reg + ADDR_W'(cnt_reg);
                wdata    = rdata_reg;
            end
            rmic_pkg::ADDR_SWEEP:
            begin
                mem_addr = sweep_addr_reg;
                wdata    = '0;
                // clear-all only zeroes fitted boards; the reset pass zeroes all
                mem_we   = cmd.mem_wr && (cmd.sweep_force ||
                           rmic_pkg::present_bit(mask_reg, 8'(sweep_bd_reg)));
            end
            default:
            begin
                mem_addr = sweep_addr_reg;
                wdata    = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            relay_image_reg[mem_addr] <= wdata;
        if (cmd.mem_rd)
            rdata_reg <= relay_image_reg[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg       <= '0;
            bse_reg        <= 1'b1;
            dirty_reg      <= '0;
            sweep_addr_reg <= '0;
            sweep_off_reg  <= '0;
            sweep_bd_reg   <= '0;
            strobe_reg     <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (rmic_pkg::cfg_index_t'(cfg_index))
                    rmic_pkg::CFG_BOARD_PRESENT_MASK:
                        mask_reg <= cfg_data;
                    rmic_pkg::CFG_BUS_SWITCH_ENABLE:
                        bse_reg <= cfg_data[0];
                    default:
                        bse_reg <= bse_reg;
                endcase
            end
            dirty_reg  <= dirty_next;
            strobe_reg <= cmd.emit;
            if (cmd.sweep_step)
            begin
                if (sweep_last)
                begin
                    sweep_addr_reg <= '0;
                    sweep_off_reg  <= '0;
                    sweep_bd_reg   <= '0;
                end
                else
                begin
                    sweep_addr_reg <= sweep_addr_reg + 1'b1;
                    if (sweep_off_reg == OFF_W'(BPB - 1))
                    begin
                        sweep_off_reg <= '0;
                        sweep_bd_reg  <= sweep_bd_reg + 1'b1;
                    end
                    else
                        sweep_off_reg <= sweep_off_reg + 1'b1;
                end
            end
            // bytes leave from the bus-switch byte down to channel 0
            if (cmd.shift_init)
                cnt_reg <= OFF_W'(BPB - 1);
            else if (cmd.shift_step && cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= rmic_pkg::opcode_t'(opcode);
            bus_reg <= bus_line;
            col_reg <= column;
            sel_reg <= board_sel;
        end
        if (cmd.divide)
            bd_reg <= quot_full[rmic_pkg::RECIP_SHIFT +: 8];
        if (cmd.decode)
        begin
            ch_reg   <= ch_full[CH_W-1:0];
            base_reg <= base_full[ADDR_W-1:0];
        end
        if (cmd.emit)
        begin
            status_reg       <= (op_reg != rmic_pkg::OP_CLEAR_ALL) && !item_ok;
            image_byte_reg   <= cmd.emit_byte ? rdata_reg : '0;
            out_board_reg    <= board_tag;
            dirty_boards_reg <= dirty_next;
            last_reg         <= !cmd.emit_byte || (cnt_reg == '0);
        end
    end

    assign strobe       = strobe_reg;
    assign status       = status_reg;
    assign image_byte   = image_byte_reg;
    assign out_board    = out_board_reg;
    assign dirty_boards = dirty_boards_reg;
    assign last         = last_reg;

    `RMIC_ASSERT_NOW(a_error_beat_single, strobe_reg && status_reg, last_reg && image_byte_reg == '0)
    `RMIC_ASSERT_NOW(a_dirty_within_boards, 1'b1, (dirty_reg & ~BOARD_LIM) == '0)

endmodule

// File: hw/rtl/relay_matrix_image_controller.sv
// ----------------------------------------------------------------------------
// relay_matrix_image_controller
// relay image store for a bank of matrix boards with a bus-switch byte each
// ----------------------------------------------------------------------------
// usage:
//   commands go in on start when busy is low; opcode picks connect, disconnect,
//   clear all or shift out, with bus_line, column and board_sel alongside.
//   every result beat shows on the result ports for one cycle with strobe high;
//   the receiver cannot stall, so it must take each beat as it comes.
//   configuration (board present mask, bus-switch enable) is written through
//   cfg_write / cfg_index / cfg_data while no command is in flight.
// steps from the accept edge to the edge that raises strobe:
//   connect or disconnect: column split, decode, channel byte read and write,
//   then the bus-switch byte read and write when connect also edits that
//   byte; a rejected command: column split, then decode; clear all: split,
//   decode, then the clearing sweep, one image byte per cycle, which zeroes
//   only the bytes of fitted boards. shift out: split, decode, then a memory
//   read and beat per byte: CHANNELS+1 beats in all, last on the final one.
//   busy drops in the cycle of the final beat, so the next command can be
//   taken at the edge that ends it.
// reset: the image is zeroed by a sweep over every image byte, during which
//   busy stays high.
// ----------------------------------------------------------------------------
module relay_matrix_image_controller #(
    parameter int BOARDS             = rmic_pkg::BOARDS_DEF,
    parameter int CHANNELS_PER_BOARD = rmic_pkg::CHANNELS_DEF,
    parameter int BUSES              = rmic_pkg::BUSES_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [rmic_pkg::OP_W-1:0]         opcode,
    input  logic [rmic_pkg::BUS_W-1:0]        bus_line,
    input  logic [rmic_pkg::COL_W-1:0]        column,
    input  logic [rmic_pkg::SEL_W-1:0]        board_sel,
    input  logic                              cfg_write,
    input  logic [rmic_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rmic_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              strobe,
    output logic                              status,
    output logic [rmic_pkg::BYTE_W-1:0]       image_byte,
    output logic [rmic_pkg::OUTB_W-1:0]       out_board,
    output logic [rmic_pkg::DIRTY_W-1:0]      dirty_boards,
    output logic                              last
);

    rmic_pkg::rmic_cmd_t  cmd;
    rmic_pkg::rmic_stat_t stat;

    rmic_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    rmic_datapath #(
        .BOARDS             (BOARDS),
        .CHANNELS_PER_BOARD (CHANNELS_PER_BOARD),
        .BUSES              (BUSES)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .opcode       (opcode),
        .bus_line     (bus_line),
        .column       (column),
        .board_sel    (board_sel),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .strobe       (strobe),
        .status       (status),
        .image_byte   (image_byte),
        .out_board    (out_board),
        .dirty_boards (dirty_boards),
        .last         (last)
    );

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: relay matrix image controller testbench
// drives connect, disconnect, clear-all and shift-out commands under several
// board and bus-switch settings, predicts every result beat from a local copy
// of the relay image and checks each strobed beat field by field
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rmic_pkg::*;

    localparam int BOARDS      = BOARDS_DEF;
    localparam int CHANNELS    = CHANNELS_DEF;
    localparam int BUSES       = BUSES_DEF;
    localparam int BOARD_BYTES = CHANNELS + 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 300;

    typedef struct packed {
        logic                status;
        logic [BYTE_W-1:0]   data;
        logic [OUTB_W-1:0]   board;
        logic [DIRTY_W-1:0]  dirty;
        logic                last;
    } beat_t;

    typedef struct packed {
        opcode_t             op;
        logic [BUS_W-1:0]    bus;
        logic [COL_W-1:0]    col;
        logic [SEL_W-1:0]    sel;
    } command_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [OP_W-1:0]        opcode;
    logic [BUS_W-1:0]       bus_line;
    logic [COL_W-1:0]       column;
    logic [SEL_W-1:0]       board_sel;
    logic                   cfg_write;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   strobe;
    logic                   status;
    logic [BYTE_W-1:0]      image_byte;
    logic [OUTB_W-1:0]      out_board;
    logic [DIRTY_W-1:0]     dirty_boards;
    logic                   last;

    // local copy of the block state and its registers
    logic [7:0]             image_copy [BOARDS*BOARD_BYTES];
    logic [DIRTY_W-1:0]     dirty_copy;
    logic [MASK_W-1:0]      present_copy;
    logic                   bus_switch_copy;

    beat_t                  pending_beats[$];
    int                     mismatch_count;
    int unsigned            cycle_count;
    bit                     steady_start;

    relay_matrix_image_controller uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .bus_line     (bus_line),
        .column       (column),
        .board_sel    (board_sel),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .strobe       (strobe),
        .status       (status),
        .image_byte   (image_byte),
        .out_board    (out_board),
        .dirty_boards (dirty_boards),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic bit board_fitted(int bd);
        return (bd < BOARDS) && present_copy[bd];
    endfunction

    function automatic logic [OUTB_W-1:0] board_tag(int bd);
        return (bd < BOARDS) ? OUTB_W'(bd) : '0;
    endfunction

    function automatic beat_t make_beat(logic st, logic [7:0] data, int bd, logic fin);
        beat_t b;
        b.status = st;
        b.data   = data;
        b.board  = board_tag(bd);
        b.dirty  = dirty_copy;
        b.last   = fin;
        return b;
    endfunction

    // update the image copy for one accepted command and queue its beats
    function automatic void apply_command(command_t c);
        int bd;
        int ch;
        int base;
        case (c.op)
            OP_CLEAR_ALL:
            begin
                for (bd = 0; bd < BOARDS; bd++)
                begin
                    if (board_fitted(bd))
                    begin
                        for (int k = 0; k < BOARD_BYTES; k++)
                            image_copy[bd*BOARD_BYTES + k] = '0;
                        dirty_copy[bd] = 1'b1;
                    end
                end
                pending_beats.push_back(make_beat(1'b0, '0, 0, 1'b1));
            end
            OP_SHIFT_OUT:
            begin
                bd = int'(c.sel);
                if (!board_fitted(bd))
                    pending_beats.push_back(make_beat(1'b1, '0, bd, 1'b1));
                else
                begin
                    dirty_copy[bd] = 1'b0;
                    // bus-switch byte first, channel 0 last
                    for (int k = 0; k < BOARD_BYTES; k++)
                        pending_beats.push_back(make_beat(1'b0,
                            image_copy[bd*BOARD_BYTES + BOARD_BYTES - 1 - k], bd,
                            k == BOARD_BYTES - 1));
                end
            end
            default:
            begin
                bd = int'(c.col) / CHANNELS;
                ch = int'(c.col) % CHANNELS;
                if (!board_fitted(bd) || int'(c.bus) >= BUSES)
                    pending_beats.push_back(make_beat(1'b1, '0, bd, 1'b1));
                else
                begin
                    base = bd * BOARD_BYTES;
                    if (c.op == OP_CONNECT)
                    begin
                        image_copy[base + ch][c.bus] = 1'b1;
                        if (bus_switch_copy)
                            image_copy[base + CHANNELS][c.bus] = 1'b1;
                    end
                    else
                        image_copy[base + ch][c.bus] = 1'b0;
                    dirty_copy[bd] = 1'b1;
                    pending_beats.push_back(make_beat(1'b0, '0, bd, 1'b1));
                end
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        beat_t want;
        if (rst_n === 1'b1 && strobe === 1'b1)
        begin
            if (pending_beats.size() == 0)
            begin
                $error("unexpected result beat");
                mismatch_count++;
            end
            else
            begin
                want = pending_beats.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatch_count++;
                end
                if (image_byte !== want.data)
                begin
                    $error("image_byte: expected %0h, got %0h", want.data, image_byte);
                    mismatch_count++;
                end
                if (out_board !== want.board)
                begin
                    $error("out_board: expected %0d, got %0d", want.board, out_board);
                    mismatch_count++;
                end
                if (dirty_boards !== want.dirty)
                begin
                    $error("dirty_boards: expected %0h, got %0h", want.dirty, dirty_boards);
                    mismatch_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_command(command_t c);
        int gap;
        gap = 0;
        if (!steady_start && $urandom_range(0, 99) < 12)
            gap = $urandom_range(1, 8);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start     <= 1'b1;
        opcode    <= c.op;
        bus_line  <= c.bus;
        column    <= c.col;
        board_sel <= c.sel;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        apply_command(c);
    endtask

    task automatic send(opcode_t op, int bus, int col, int sel);
        command_t c;
        c.op  = op;
        c.bus = BUS_W'(bus);
        c.col = COL_W'(col);
        c.sel = SEL_W'(sel);
        send_command(c);
    endtask

    // drop start and let every outstanding beat arrive
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_BOARD_PRESENT_MASK)
            present_copy = value[MASK_W-1:0];
        else
            bus_switch_copy = value[0];
    endtask

    function automatic command_t random_command();
        command_t c;
        int fitted[$];
        int pick;
        int bd;
        for (int b = 0; b < BOARDS; b++)
            if (board_fitted(b))
                fitted.push_back(b);
        c.op  = opcode_t'($urandom_range(0, 3));
        c.bus = BUS_W'($urandom_range(0, 7));
        c.col = COL_W'($urandom_range(0, 255));
        c.sel = SEL_W'($urandom_range(0, 7));
        pick  = $urandom_range(0, 99);
        // mostly edits and shift-outs on fitted boards, the rest is noise
        if (fitted.size() != 0 && pick < 92)
        begin
            bd = fitted[$urandom_range(0, fitted.size() - 1)];
            if (pick < 72)
            begin
                c.op  = (pick < 50) ? OP_CONNECT : OP_DISCONNECT;
                c.col = COL_W'(bd * CHANNELS + $urandom_range(0, CHANNELS - 1));
            end
            else if (pick < 76)
                c.op = OP_CLEAR_ALL;
            else
            begin
                c.op  = OP_SHIFT_OUT;
                c.sel = SEL_W'(bd);
            end
        end
        return c;
    endfunction

    task automatic test_connect_disconnect();
        write_register(CFG_BOARD_PRESENT_MASK, 5'b11111);
        write_register(CFG_BUS_SWITCH_ENABLE, 5'd1);
        send(OP_CONNECT, 0, 0, 0);
        send(OP_CONNECT, 7, 45, 0);
        send(OP_CONNECT, 3, 46, 0);
        send(OP_CONNECT, 5, 229, 7);
        // bus-switch bit must survive the disconnect
        send(OP_DISCONNECT, 7, 45, 0);
        send(OP_CONNECT, 7, 230, 0);
        send(OP_DISCONNECT, 7, 255, 7);
        send(OP_SHIFT_OUT, 0, 0, 0);
        send(OP_SHIFT_OUT, 0, 0, 1);
        send(OP_SHIFT_OUT, 0, 0, 4);
    endtask

    task automatic test_missing_board();
        write_register(CFG_BOARD_PRESENT_MASK, 5'b00101);
        send(OP_CONNECT, 2, 50, 0);
        send(OP_SHIFT_OUT, 0, 0, 1);
        send(OP_SHIFT_OUT, 0, 0, 5);
        send(OP_SHIFT_OUT, 0, 0, 7);
    endtask

    task automatic test_bus_switch_disable();
        write_register(CFG_BUS_SWITCH_ENABLE, 5'd0);
        send(OP_CONNECT, 6, 100, 0);
        send(OP_SHIFT_OUT, 0, 0, 2);
    endtask

    task automatic test_shift_clean_board();
        send(OP_SHIFT_OUT, 0, 0, 2);
    endtask

    task automatic test_clear_all();
        write_register(CFG_BOARD_PRESENT_MASK, 5'b00000);
        send(OP_CLEAR_ALL, 0, 0, 0);
        write_register(CFG_BOARD_PRESENT_MASK, 5'b10001);
        send(OP_CLEAR_ALL, 0, 0, 0);
        send(OP_SHIFT_OUT, 0, 0, 0);
        send(OP_SHIFT_OUT, 0, 0, 4);
    endtask

    task automatic random_phase(logic [MASK_W-1:0] mask, logic bse, int count, bit steady);
        write_register(CFG_BOARD_PRESENT_MASK, mask);
        write_register(CFG_BUS_SWITCH_ENABLE, {4'b0000, bse});
        steady_start = steady;
        repeat (count) send_command(random_command());
        steady_start = 1'b0;
    endtask

    task automatic test_random_traffic();
        random_phase(5'b11111, 1'b1, 35, 1'b0);
        random_phase(MASK_W'($urandom_range(1, 30)), 1'b0, 30, 1'b1);
        random_phase(5'b00000, 1'($urandom_range(0, 1)), 10, 1'b0);
        random_phase(MASK_W'($urandom_range(1, 31)), 1'b1, 35, 1'b0);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        opcode          = '0;
        bus_line        = '0;
        column          = '0;
        board_sel       = '0;
        cfg_write       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        mismatch_count  = 0;
        cycle_count     = 0;
        steady_start    = 1'b0;
        dirty_copy      = '0;
        present_copy    = '0;
        bus_switch_copy = 1'b1;
        foreach (image_copy[i])
            image_copy[i] = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_connect_disconnect();
        test_missing_board();
        test_bus_switch_disable();
        test_shift_clean_board();
        test_clear_all();
        test_random_traffic();

        wait_idle();
        // catch any stray beat after the final one
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/rmic_pkg.sv
hw/rtl/rmic_ctrl.sv
hw/rtl/rmic_datapath.sv
hw/rtl/relay_matrix_image_controller.sv
tb/tb.sv
